/* rtl/u2u8_pkg.sv */
// Package for the UCS-2 to UTF-8 encoder: item types, the unit record
// passed from the encode stage to the byte emitter, and encoding constants.
// No dependencies.
`default_nettype none
package u2u8_pkg;

  localparam logic [15:0] CAP_RESET   = 16'hFFFF;
  localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
  localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
  localparam logic [2:0]  LEAD2_TAG   = 3'b110;
  localparam logic [3:0]  LEAD3_TAG   = 4'b1110;
  localparam logic [1:0]  CONT_TAG    = 2'b10;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic        byte_valid;
    logic        last_of_run;
    logic [15:0] bytes_written;
    logic        truncated;
  } out_item_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      num;
    logic [15:0]     written;
    logic            truncated;
  } unit_t;

endpackage
`default_nettype wire

/* rtl/ucs2_to_utf8_encoder.sv */
// UCS-2 to UTF-8 encoder, top level: capacity register, encode stage and
// byte emitter. Depends on u2u8_pkg, u2u8_encode, u2u8_emit.
//
// Input channel (in_valid/in_ready/in_data) takes one 16-bit code unit per
// item with a last_unit mark. Result channel (out_valid/out_ready/out_data)
// gives one item per UTF-8 byte: one, two or three per unit, or a single
// empty item with truncated set once a unit of its string overruns capacity.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes the per-string
// byte capacity; it is always ready.
// The first result of a unit is offered the cycle after the unit is
// accepted. The single byte emitter hands out the results of a unit one
// at a time as the receiver takes them; a new unit is accepted in the
// cycle the last byte of the previous one is taken.
// Reset clears the byte count, the truncation state and the emitter, and
// sets capacity to 65535. When the receiver stalls, the current result is
// held and in_ready drops once the emitter holds a unit that is not on its
// last byte or is not being taken.
`default_nettype none
module ucs2_to_utf8_encoder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire u2u8_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output u2u8_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [15:0]         cfg_data
);
  import u2u8_pkg::*;

  logic [15:0] capacity_r;
  logic        in_take;
  logic        free;
  unit_t       unit;

  assign cfg_ready = 1'b1;
  assign in_ready  = free;
  assign in_take   = in_valid && free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity_r <= cfg_data;
    end
  end

  u2u8_encode u_encode (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (in_take),
    .item     (in_data),
    .capacity (capacity_r),
    .unit     (unit)
  );

  u2u8_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_take),
    .unit_in   (unit),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* rtl/u2u8_encode.sv */
// Encode stage: turns one code unit into its UTF-8 bytes and keeps the
// per-string byte count and truncation state. Depends on u2u8_pkg.
`default_nettype none
module u2u8_encode (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             take,
  input  wire u2u8_pkg::in_item_t item,
  input  wire logic [15:0]      capacity,
  output u2u8_pkg::unit_t       unit
);
  import u2u8_pkg::*;

  logic [15:0] byte_count_r, byte_count_nxt;
  logic        stopped_r, stopped_nxt;
  logic [1:0]  num;
  logic [2:0][7:0] bytes;
  logic [17:0] need;
  logic        stop;
  logic [15:0] cu;

  assign cu = item.code_unit;

  always_comb begin
    bytes = '0;
    if (cu <= ONE_BYTE_MAX) begin
      num      = 2'd1;
      bytes[0] = {1'b0, cu[6:0]};
    end else if (cu <= TWO_BYTE_MAX) begin
      num      = 2'd2;
      bytes[0] = {LEAD2_TAG, cu[10:6]};
      bytes[1] = {CONT_TAG, cu[5:0]};
    end else begin
      num      = 2'd3;
      bytes[0] = {LEAD3_TAG, cu[15:12]};
      bytes[1] = {CONT_TAG, cu[11:6]};
      bytes[2] = {CONT_TAG, cu[5:0]};
    end
  end

  assign need = {2'b00, byte_count_r} + {16'd0, num};
  assign stop = stopped_r || (need > {2'b00, capacity});

  always_comb begin
    unit.truncated = stop;
    unit.num       = stop ? 2'd1 : num;
    unit.bytes     = stop ? '0 : bytes;
    unit.written   = stop ? byte_count_r : byte_count_r + 16'd1;
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    stopped_nxt    = stopped_r;
    if (take) begin
      if (item.last_unit) begin
        byte_count_nxt = '0;
        stopped_nxt    = 1'b0;
      end else if (stop) begin
        stopped_nxt    = 1'b1;
      end else begin
        byte_count_nxt = need[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      stopped_r    <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/u2u8_emit.sv */
// Byte emitter: holds one encoded unit and hands out its bytes one item
// per cycle on the result channel unless stalled. Depends on u2u8_pkg.
`default_nettype none
module u2u8_emit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire u2u8_pkg::unit_t    unit_in,
  output logic                    free,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output u2u8_pkg::out_item_t     out_data
);
  import u2u8_pkg::*;

  logic       unit_valid_r, unit_valid_nxt;
  unit_t      unit_r;
  logic [1:0] idx_r, idx_nxt;
  logic       last_byte;
  logic       out_take;

  assign last_byte = (idx_r == unit_r.num - 2'd1);
  assign out_valid = unit_valid_r;
  assign out_take  = unit_valid_r && out_ready;
  assign free      = !unit_valid_r || (out_ready && last_byte);

  always_comb begin
    out_data.byte_value    = unit_r.bytes[idx_r];
    out_data.byte_valid    = !unit_r.truncated;
    out_data.last_of_run   = last_byte;
    out_data.bytes_written = unit_r.written + {14'd0, idx_r};
    out_data.truncated     = unit_r.truncated;
  end

  always_comb begin
    unit_valid_nxt = unit_valid_r;
    idx_nxt        = idx_r;
    if (load) begin
      unit_valid_nxt = 1'b1;
      idx_nxt        = '0;
    end else if (out_take) begin
      if (last_byte) begin
        unit_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_valid_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      unit_valid_r <= unit_valid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unit_r <= unit_in;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    unit_valid_r |-> (idx_r < unit_r.num))
    else $error("byte index past unit length");

  a_trunc_single: assert property (@(posedge clk) disable iff (!rst_n)
    (unit_valid_r && unit_r.truncated) |-> (unit_r.num == 2'd1))
    else $error("truncated unit with more than one result");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && last_byte && !load) |=> !unit_valid_r)
    else $error("unit not released after last byte");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !last_byte) |=> (unit_valid_r && idx_r == $past(idx_r) + 2'd1))
    else $error("byte index did not advance");

endmodule
`default_nettype wire

/* bench/utf8_byte_checker.sv */
// Checker for the UCS-2 to UTF-8 encoder: predicts the UTF-8 byte items of
// every accepted code unit and compares them with the result channel.
// Depends on u2u8_pkg.
module utf8_byte_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  u2u8_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  u2u8_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  output int                  mismatches,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import u2u8_pkg::*;

  logic [15:0] capacity;
  logic [15:0] string_bytes;
  logic        string_stopped;
  out_item_t   expected_bytes[$];
  int          fail_total = 0;

  function automatic void predict_utf8_bytes(input in_item_t unit);
    logic [7:0] enc[3];
    int         n;
    out_item_t  r;
    if (unit.code_unit <= ONE_BYTE_MAX) begin
      n = 1;
      enc[0] = {1'b0, unit.code_unit[6:0]};
    end else if (unit.code_unit <= TWO_BYTE_MAX) begin
      n = 2;
      enc[0] = {LEAD2_TAG, unit.code_unit[10:6]};
      enc[1] = {CONT_TAG, unit.code_unit[5:0]};
    end else begin
      n = 3;
      enc[0] = {LEAD3_TAG, unit.code_unit[15:12]};
      enc[1] = {CONT_TAG, unit.code_unit[11:6]};
      enc[2] = {CONT_TAG, unit.code_unit[5:0]};
    end
    if (!string_stopped && (int'(string_bytes) + n > int'(capacity)))
      string_stopped = 1'b1;
    if (string_stopped) begin
      r.byte_value    = 8'h00;
      r.byte_valid    = 1'b0;
      r.last_of_run   = 1'b1;
      r.bytes_written = string_bytes;
      r.truncated     = 1'b1;
      expected_bytes.push_back(r);
    end else begin
      for (int i = 0; i < n; i++) begin
        string_bytes    = string_bytes + 16'd1;
        r.byte_value    = enc[i];
        r.byte_valid    = 1'b1;
        r.last_of_run   = (i == n - 1);
        r.bytes_written = string_bytes;
        r.truncated     = 1'b0;
        expected_bytes.push_back(r);
      end
    end
    if (unit.last_unit) begin
      string_bytes   = '0;
      string_stopped = 1'b0;
    end
  endfunction

  function automatic void report_field(input string field, input longint want,
                                       input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      fail_total++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      capacity       = CAP_RESET;
      string_bytes   = '0;
      string_stopped = 1'b0;
      expected_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        capacity = cfg_data;
      if (in_valid && in_ready)
        predict_utf8_bytes(in_data);
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: result expected none actual %p", $time, out_data);
          fail_total++;
        end else begin
          want = expected_bytes.pop_front();
          report_field("byte_value", want.byte_value, out_data.byte_value);
          report_field("byte_valid", want.byte_valid, out_data.byte_valid);
          report_field("last_of_run", want.last_of_run, out_data.last_of_run);
          report_field("bytes_written", want.bytes_written, out_data.bytes_written);
          report_field("truncated", want.truncated, out_data.truncated);
        end
      end
    end
    mismatches  <= fail_total;
    outstanding <= expected_bytes.size();
  end

endmodule

/* bench/tb.sv */
// Testbench top for the UCS-2 to UTF-8 encoder: clock, reset, code unit and
// capacity stimulus, receiver backpressure and the verdict.
// Depends on u2u8_pkg, ucs2_to_utf8_encoder and utf8_byte_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import u2u8_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  int          mismatches;
  int          outstanding;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_off_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ucs2_to_utf8_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  utf8_byte_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  task automatic offer_unit(input logic [15:0] code, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{code_unit: code, last_unit: last};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_bytes();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_capacity(input logic [15:0] cap);
    drain_bytes();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_strings(input int units);
    int          left;
    logic        last;
    logic [15:0] code;
    left = units;
    while (left > 0) begin
      left--;
      last = (left == 0) || ($urandom_range(4) == 0);
      case ($urandom_range(2))
        0:       code = 16'($urandom_range(16'h007F));
        1:       code = 16'($urandom_range(16'h07FF, 16'h0080));
        default: code = 16'($urandom_range(16'hFFFF, 16'h0800));
      endcase
      offer_unit(code, last);
    end
  endtask

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        out_ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++)
      @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    set_capacity(16'hFFFF);
    offer_unit(16'h0000, 1'b0);
    offer_unit(16'h007F, 1'b0);
    offer_unit(16'h0080, 1'b0);
    offer_unit(16'h07FF, 1'b0);
    offer_unit(16'h0800, 1'b0);
    offer_unit(16'hD800, 1'b0);
    offer_unit(16'hDFFF, 1'b0);
    offer_unit(16'hFFFF, 1'b1);

    // zero capacity: truncate on the first unit of every string
    set_capacity(16'h0000);
    offer_unit(16'h0041, 1'b0);
    offer_unit(16'h0042, 1'b1);
    offer_unit(16'h0000, 1'b1);

    set_capacity(16'h0003);
    offer_unit(16'h0800, 1'b0);
    offer_unit(16'h0041, 1'b0);
    offer_unit(16'h07FF, 1'b1);
    offer_unit(16'h0041, 1'b1);

    set_capacity(16'h0001);
    offer_unit(16'h0080, 1'b0);
    offer_unit(16'h0041, 1'b1);

    set_capacity(16'h0002);
    offer_unit(16'h0041, 1'b0);
    offer_unit(16'h0042, 1'b0);
    offer_unit(16'h0043, 1'b1);

    send_idle_pct = 32;
    recv_idle_pct = 45;
    set_capacity(16'($urandom_range(10, 1)));
    send_strings(70);

    send_idle_pct = 45;
    recv_idle_pct = 32;
    set_capacity(16'hFFFF);
    hold_off_left = 300;
    send_strings(70);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_capacity(16'($urandom_range(16'hFFFF)));
    send_strings(30);
    set_capacity(16'($urandom_range(16, 0)));
    send_strings(40);

    drain_bytes();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/u2u8_pkg.sv
rtl/u2u8_encode.sv
rtl/u2u8_emit.sv
rtl/ucs2_to_utf8_encoder.sv
bench/utf8_byte_checker.sv
bench/tb.sv
